[hw/rtl/second_order_leso_update_defines.svh]
// Assertion macros for the second-order LESO block.
// Used by the port-level checker; expects clk and rst in scope.
`ifndef SECOND_ORDER_LESO_UPDATE_DEFINES_SVH
`define SECOND_ORDER_LESO_UPDATE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SOLESO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SOLESO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/soleso_pkg.sv]
// Shared types and constants for the second-order LESO block.
// No dependencies; imported by every RTL module of the block except the checker.
package soleso_pkg;

  localparam int MUL_W      = 32;   // shared multiplier operand width
  localparam int GAIN_W     = 48;   // unsigned Q32.16 gains
  localparam int PERIOD_W   = 32;   // unsigned Q0.32 sample period
  localparam int IGAIN_W    = 32;   // signed Q16.16 input gain
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int ADDR_LSB   = 3;    // registers on 8-byte spacing

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd4294967;
  localparam logic [IGAIN_W-1:0]  IGAIN_RESET  = 32'd65536;

  typedef enum logic [APB_ADDR_W-ADDR_LSB-1:0] {
    REG_PERIOD,
    REG_GAIN_POS,
    REG_GAIN_VEL,
    REG_GAIN_DIST,
    REG_INPUT_GAIN
  } reg_idx_t;

  typedef enum logic {
    CMD_UPDATE,
    CMD_INIT
  } command_t;

  // products in the order they are computed for an update
  typedef enum logic [2:0] {
    OP_GP,   // gain_position * e
    OP_GV,   // gain_velocity * e
    OP_GD,   // gain_disturbance * e
    OP_IU,   // input_gain * u
    OP_R1,   // position rate * T
    OP_R2,   // velocity rate * T
    OP_R3    // disturbance rate * T
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INIT,
    ST_ERR,
    ST_LOAD,
    ST_MUL,
    ST_DRAIN,
    ST_SIGN,
    ST_WB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [GAIN_W-1:0]   gain_pos;
    logic [GAIN_W-1:0]   gain_vel;
    logic [GAIN_W-1:0]   gain_dist;
    logic [IGAIN_W-1:0]  input_gain;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic init;
    logic err;
    logic load;
    logic step;
    logic sign;
    logic wb;
    logic publish;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic init_cmd;
    logic mul_last;
  } status_t;

  function automatic op_t next_op(op_t op);
    op_t nxt;
    unique case (op)
      OP_GP:   nxt = OP_GV;
      OP_GV:   nxt = OP_GD;
      OP_GD:   nxt = OP_IU;
      OP_IU:   nxt = OP_R1;
      OP_R1:   nxt = OP_R2;
      OP_R2:   nxt = OP_R3;
      default: nxt = OP_GP;
    endcase
    return nxt;
  endfunction

endpackage

[hw/rtl/soleso_regs.sv]
// APB register file for the LESO block: period, three gains, input gain.
// Depends on soleso_pkg.
module soleso_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [soleso_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [soleso_pkg::APB_DATA_W-1:0] pwdata,
  output logic [soleso_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready,
  output soleso_pkg::cfg_t                  cfg
);
  import soleso_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:ADDR_LSB]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period     <= PERIOD_RESET;
      cfg.gain_pos   <= '0;
      cfg.gain_vel   <= '0;
      cfg.gain_dist  <= '0;
      cfg.input_gain <= IGAIN_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_PERIOD:     cfg.period     <= pwdata[PERIOD_W-1:0];
        REG_GAIN_POS:   cfg.gain_pos   <= pwdata[GAIN_W-1:0];
        REG_GAIN_VEL:   cfg.gain_vel   <= pwdata[GAIN_W-1:0];
        REG_GAIN_DIST:  cfg.gain_dist  <= pwdata[GAIN_W-1:0];
        REG_INPUT_GAIN: cfg.input_gain <= pwdata[IGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PERIOD:     prdata = APB_DATA_W'(cfg.period);
      REG_GAIN_POS:   prdata = APB_DATA_W'(cfg.gain_pos);
      REG_GAIN_VEL:   prdata = APB_DATA_W'(cfg.gain_vel);
      REG_GAIN_DIST:  prdata = APB_DATA_W'(cfg.gain_dist);
      REG_INPUT_GAIN: prdata = APB_DATA_W'(cfg.input_gain);
      default:        prdata = '0;
    endcase
  end

endmodule

[hw/rtl/soleso_ctrl.sv]
// Sequencer for the LESO block: steps the datapath through the seven
// products of an update and owns both handshakes. Depends on soleso_pkg.
module soleso_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  soleso_pkg::status_t status,
  output soleso_pkg::cmd_t    cmd
);
  import soleso_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_GP;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.op     = op;
    state_next = state;
    op_next    = op;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.init_cmd) begin
          state_next = ST_INIT;
        end else begin
          state_next = ST_ERR;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_DONE;
      end
      ST_ERR: begin
        cmd.err    = 1'b1;
        op_next    = OP_GP;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.step = 1'b1;
        if (status.mul_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last partial product lands in the accumulator
      ST_DRAIN: state_next = ST_SIGN;
      ST_SIGN: begin
        cmd.sign   = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        if (op == OP_R3) begin
          state_next = ST_DONE;
        end else begin
          op_next    = next_op(op);
          state_next = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/soleso_dp.sv]
// Datapath for the LESO block: observer states, one shared 32x32 multiplier
// stepping over operand chunks, accumulator, saturation. Depends on soleso_pkg.
module soleso_dp #(
  parameter int STATE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  soleso_pkg::cmd_t              cmd,
  output soleso_pkg::status_t           status,
  input  soleso_pkg::cfg_t              cfg,
  input  logic                          command,
  input  logic signed [STATE_WIDTH-1:0] measured_output,
  input  logic signed [STATE_WIDTH-1:0] control_input,
  output logic signed [STATE_WIDTH-1:0] position_estimate,
  output logic signed [STATE_WIDTH-1:0] velocity_estimate,
  output logic signed [STATE_WIDTH-1:0] disturbance_estimate,
  output logic                          is_initialized
);
  import soleso_pkg::*;

  localparam int W   = STATE_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int CW  = MUL_W;
  localparam int RW  = GAIN_W + 4 + W - F;     // rate width, signed
  localparam int SW  = RW + 1;                 // state + increment
  localparam int AW  = (RW > GAIN_W) ? RW : GAIN_W;
  localparam int NA  = (AW + CW - 1) / CW;     // chunks of the long operand
  localparam int NB  = (W + 1 + CW - 1) / CW;  // chunks of the short operand
  localparam int NG  = (GAIN_W + CW - 1) / CW;
  localparam int NU  = (W + CW - 1) / CW;
  localparam int NR  = (RW + CW - 1) / CW;
  localparam int AOW = CW * NA;
  localparam int BOW = CW * NB;
  localparam int ACW = CW * (NA + NB);
  localparam int KW  = $clog2(NA + NB);

  localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  command_t               cmd_reg;
  logic signed [W-1:0]    y, u;
  logic signed [W-1:0]    pos, vel, disturb;
  logic                   init_done;
  logic signed [W:0]      err;

  logic [AOW-1:0]         opa;
  logic [BOW-1:0]         opb;
  logic                   neg;
  logic [KW-1:0]          ai, bi, a_lim, b_lim, pk;
  logic [2*CW-1:0]        prod;
  logic                   pv;
  logic [ACW-1:0]         acc;
  logic signed [ACW:0]    res;
  logic signed [RW-1:0]   r1, r2, r3;

  logic [W:0]             e_mag;
  logic [W-1:0]           u_mag;
  logic signed [IGAIN_W-1:0] ig;
  logic [IGAIN_W-1:0]     ig_mag;
  logic signed [RW-1:0]   r_sel;
  logic [RW-1:0]          r_mag;
  logic [GAIN_W-1:0]      gain_sel;
  logic signed [ACW:0]    res_f, res_t;
  logic signed [RW-1:0]   term, rate_t;
  logic signed [W-1:0]    base_sel, sat_val;
  logic signed [SW-1:0]   sum;
  logic                   is_gain;

  // ---- operand selection and magnitudes ----
  assign ig      = $signed(cfg.input_gain);
  assign e_mag   = err[W] ? $unsigned(-err) : $unsigned(err);
  assign u_mag   = u[W-1] ? $unsigned(-u) : $unsigned(u);
  assign ig_mag  = ig[IGAIN_W-1] ? $unsigned(-ig) : $unsigned(ig);
  assign r_mag   = r_sel[RW-1] ? $unsigned(-r_sel) : $unsigned(r_sel);
  assign is_gain = (cmd.op == OP_GP) || (cmd.op == OP_GV) || (cmd.op == OP_GD);

  always_comb begin
    unique case (cmd.op)
      OP_GV:   gain_sel = cfg.gain_vel;
      OP_GD:   gain_sel = cfg.gain_dist;
      default: gain_sel = cfg.gain_pos;
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      OP_R1:   begin r_sel = r1; base_sel = pos; end
      OP_R2:   begin r_sel = r2; base_sel = vel; end
      default: begin r_sel = r3; base_sel = disturb; end
    endcase
  end

  // ---- capture and error ----
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      y       <= measured_output;
      u       <= control_input;
      cmd_reg <= command_t'(command);
    end
    if (cmd.err) begin
      err <= $signed({y[W-1], y}) - $signed({pos[W-1], pos});
    end
  end

  assign status.init_cmd = (cmd_reg == CMD_INIT);

  // ---- operand load ----
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (is_gain) begin
        opa   <= AOW'(gain_sel);
        opb   <= BOW'(e_mag);
        neg   <= err[W];
        a_lim <= KW'(NG - 1);
        b_lim <= KW'(NB - 1);
      end else if (cmd.op == OP_IU) begin
        opa   <= AOW'(ig_mag);
        opb   <= BOW'(u_mag);
        neg   <= ig[IGAIN_W-1] ^ u[W-1];
        a_lim <= '0;
        b_lim <= KW'(NU - 1);
      end else begin
        opa   <= AOW'(r_mag);
        opb   <= BOW'(cfg.period);
        neg   <= r_sel[RW-1];
        a_lim <= KW'(NR - 1);
        b_lim <= '0;
      end
    end
  end

  // ---- chunked multiply: one partial product per cycle, registered,
  //      then shifted into the accumulator on the following cycle ----
  assign status.mul_last = (ai == a_lim) && (bi == b_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      ai <= '0;
      bi <= '0;
      pv <= 1'b0;
    end else if (cmd.load) begin
      ai <= '0;
      bi <= '0;
      pv <= 1'b0;
    end else begin
      pv <= cmd.step;
      if (cmd.step) begin
        if (bi == b_lim) begin
          bi <= '0;
          ai <= ai + KW'(1);
        end else begin
          bi <= bi + KW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      prod <= opa[ai*CW +: CW] * opb[bi*CW +: CW];
      pk   <= ai + bi;
    end
    if (cmd.load) begin
      acc <= '0;
    end else if (pv) begin
      acc <= acc + (ACW'(prod) << (CW * pk));
    end
    if (cmd.sign) begin
      res <= neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
    end
  end

  // ---- writeback: floor shifts, accumulate rates, saturate states ----
  assign res_f  = res >>> F;
  assign res_t  = res >>> PERIOD_W;
  assign term   = $signed(res_f[RW-1:0]);
  assign rate_t = $signed(res_t[RW-1:0]);
  assign sum    = SW'(rate_t) + SW'(base_sel);

  always_comb begin
    if (sum > SMAX) begin
      sat_val = {1'b0, {(W-1){1'b1}}};
    end else if (sum < SMIN) begin
      sat_val = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_val = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      unique case (cmd.op)
        OP_GP:   r1 <= term + RW'(vel);
        OP_GV:   r2 <= term + RW'(disturb);
        OP_GD:   r3 <= term;
        OP_IU:   r2 <= r2 + term;
        default: ;
      endcase
    end
  end

  // rates are all formed before any state is overwritten
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      vel       <= '0;
      disturb   <= '0;
      init_done <= 1'b0;
    end else if (cmd.init && !init_done) begin
      pos       <= y;
      vel       <= '0;
      disturb   <= '0;
      init_done <= 1'b1;
    end else if (cmd.wb) begin
      unique case (cmd.op)
        OP_R1:   pos     <= sat_val;
        OP_R2:   vel     <= sat_val;
        OP_R3:   disturb <= sat_val;
        default: ;
      endcase
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      position_estimate    <= pos;
      velocity_estimate    <= vel;
      disturbance_estimate <= disturb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_initialized <= 1'b0;
    end else if (cmd.publish) begin
      is_initialized <= init_done;
    end
  end

endmodule

[hw/rtl/second_order_leso_update.sv]
// Top level of the second-order LESO update block: APB registers, sequencer
// and datapath. Depends on soleso_pkg, soleso_regs, soleso_ctrl, soleso_dp.
//
// Each input beat is either an init (command 1) or an update (command 0); each
// yields exactly one result beat with the three state estimates after the step.
// Items are handled one at a time. An update is carried by the single
// 32x32 multiplier, which walks the 32-bit chunk pairs of seven products
// in turn, with load, drain, sign and writeback states around each. A
// finished result sits in an output register, so the next beat can be
// taken while it waits. No clearing pass follows reset; registers are at
// their reset values immediately.
module second_order_leso_update #(
  parameter int STATE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic signed [STATE_WIDTH-1:0]     measured_output,
  input  logic signed [STATE_WIDTH-1:0]     control_input,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [STATE_WIDTH-1:0]     position_estimate,
  output logic signed [STATE_WIDTH-1:0]     velocity_estimate,
  output logic signed [STATE_WIDTH-1:0]     disturbance_estimate,
  output logic                              is_initialized,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [soleso_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [soleso_pkg::APB_DATA_W-1:0] pwdata,
  output logic [soleso_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready
);
  import soleso_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  soleso_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  soleso_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  soleso_dp #(
    .STATE_WIDTH   (STATE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .cfg                  (cfg),
    .command              (command),
    .measured_output      (measured_output),
    .control_input        (control_input),
    .position_estimate    (position_estimate),
    .velocity_estimate    (velocity_estimate),
    .disturbance_estimate (disturbance_estimate),
    .is_initialized       (is_initialized)
  );

endmodule

[hw/rtl/soleso_checker.sv]
// Port-level checker for second_order_leso_update, bound to the top level.
// Depends on second_order_leso_update_defines.svh.
`include "second_order_leso_update_defines.svh"

module soleso_checker #(
  parameter int STATE_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [STATE_WIDTH-1:0] position_estimate,
  input logic [STATE_WIDTH-1:0] velocity_estimate,
  input logic [STATE_WIDTH-1:0] disturbance_estimate,
  input logic                   is_initialized
);

  // a stalled result beat stays put
  `SOLESO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
  `SOLESO_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(position_estimate) && $stable(velocity_estimate) && $stable(disturbance_estimate) && $stable(is_initialized), "stalled result beat changed")

  // one item at a time; its result cannot appear on the cycle after accept
  `SOLESO_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall && !$rose(out_valid), "block not busy after accepting a beat")

  // initialization is sticky until reset
  `SOLESO_ASSERT_NEXT(a_init_sticky, is_initialized, is_initialized, "is_initialized dropped")

endmodule

bind second_order_leso_update soleso_checker #(
  .STATE_WIDTH (STATE_WIDTH)
) u_soleso_checker (.*);

[dv/leso_update_checker.sv]
// Scoreboard for second_order_leso_update: predicts the observer states per beat and
// compares every result beat against the oldest prediction.
// Depends on soleso_pkg for register indexes, command codes and reset values.
module leso_update_checker #(
  parameter int STATE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic                                  command,
  input  logic signed [STATE_WIDTH-1:0]         measured_output,
  input  logic signed [STATE_WIDTH-1:0]         control_input,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [STATE_WIDTH-1:0]         position_estimate,
  input  logic signed [STATE_WIDTH-1:0]         velocity_estimate,
  input  logic signed [STATE_WIDTH-1:0]         disturbance_estimate,
  input  logic                                  is_initialized,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic                                  pready,
  input  logic [soleso_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [soleso_pkg::APB_DATA_W-1:0]     pwdata,
  output int                                    errors,
  output int                                    pending,
  output int                                    checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import soleso_pkg::*;

  localparam logic signed [STATE_WIDTH-1:0] SAT_HI = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0] SAT_LO = {1'b1, {(STATE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [STATE_WIDTH-1:0] position;
    logic signed [STATE_WIDTH-1:0] velocity;
    logic signed [STATE_WIDTH-1:0] disturbance;
    logic                          ready;
  } estimate_t;

  // shadow copy of the register file
  logic [PERIOD_W-1:0]          period_q032 = PERIOD_RESET;
  logic [GAIN_W-1:0]            k_pos = '0;
  logic [GAIN_W-1:0]            k_vel = '0;
  logic [GAIN_W-1:0]            k_dist = '0;
  logic signed [IGAIN_W-1:0]    b0_gain = IGAIN_RESET;

  logic signed [STATE_WIDTH-1:0] pos_est = '0;
  logic signed [STATE_WIDTH-1:0] vel_est = '0;
  logic signed [STATE_WIDTH-1:0] dist_est = '0;
  logic                          observer_ready = 1'b0;

  estimate_t expected_estimates[$];
  int fail_count = 0;
  int checked_count = 0;

  // gain * err in Q.F, floored
  function automatic logic signed [127:0] gain_product(logic [GAIN_W-1:0] gain,
                                                       logic signed [127:0] err);
    logic signed [127:0] wide_gain;
    wide_gain = $signed({{(128-GAIN_W){1'b0}}, gain});
    return (wide_gain * err) >>> FRACTION_BITS;
  endfunction

  // one Euler step: prev + floor(rate * T / 2^32), clamped to the state range
  function automatic logic signed [STATE_WIDTH-1:0] integrate(
      logic signed [STATE_WIDTH-1:0] prev, logic signed [127:0] rate);
    logic signed [127:0] wide_period;
    logic signed [127:0] sum;
    wide_period = $signed({{(128-PERIOD_W){1'b0}}, period_q032});
    sum = ((rate * wide_period) >>> 32) + prev;
    if (sum > SAT_HI) return SAT_HI;
    if (sum < SAT_LO) return SAT_LO;
    return sum[STATE_WIDTH-1:0];
  endfunction

  function automatic estimate_t advance_observer(command_t op,
                                                 logic signed [STATE_WIDTH-1:0] y,
                                                 logic signed [STATE_WIDTH-1:0] u);
    logic signed [127:0] err;
    logic signed [127:0] wide_b0;
    logic signed [127:0] wide_u;
    logic signed [127:0] drive;
    logic signed [127:0] rate_pos;
    logic signed [127:0] rate_vel;
    logic signed [127:0] rate_dist;
    logic signed [STATE_WIDTH-1:0] next_pos;
    logic signed [STATE_WIDTH-1:0] next_vel;
    logic signed [STATE_WIDTH-1:0] next_dist;
    estimate_t after;
    if (op == CMD_INIT) begin
      // only the first init loads; later ones just report
      if (!observer_ready) begin
        pos_est = y;
        vel_est = '0;
        dist_est = '0;
        observer_ready = 1'b1;
      end
    end else begin
      err = y - pos_est;
      wide_b0 = b0_gain;
      wide_u = u;
      drive = (wide_b0 * wide_u) >>> FRACTION_BITS;
      rate_pos = gain_product(k_pos, err) + vel_est;
      rate_vel = gain_product(k_vel, err) + dist_est + drive;
      rate_dist = gain_product(k_dist, err);
      next_pos = integrate(pos_est, rate_pos);
      next_vel = integrate(vel_est, rate_vel);
      next_dist = integrate(dist_est, rate_dist);
      pos_est = next_pos;
      vel_est = next_vel;
      dist_est = next_dist;
    end
    after.position = pos_est;
    after.velocity = vel_est;
    after.disturbance = dist_est;
    after.ready = observer_ready;
    return after;
  endfunction

  task automatic compare_field(string label, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    estimate_t want;
    if (rst) begin
      period_q032 = PERIOD_RESET;
      k_pos = '0;
      k_vel = '0;
      k_dist = '0;
      b0_gain = IGAIN_RESET;
      pos_est = '0;
      vel_est = '0;
      dist_est = '0;
      observer_ready = 1'b0;
      expected_estimates.delete();
    end else begin
      // retire before predicting: a new beat can't produce its result on the same edge
      if (out_valid && !out_stall) begin
        if (expected_estimates.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none actual pos %0d vel %0d dist %0d",
                   $time, position_estimate, velocity_estimate, disturbance_estimate);
        end else begin
          want = expected_estimates.pop_front();
          checked_count++;
          compare_field("position_estimate", want.position, position_estimate);
          compare_field("velocity_estimate", want.velocity, velocity_estimate);
          compare_field("disturbance_estimate", want.disturbance, disturbance_estimate);
          compare_field("is_initialized", want.ready, is_initialized);
        end
      end
      if (in_valid && !in_stall)
        expected_estimates.push_back(advance_observer(command_t'(command), measured_output,
                                                      control_input));
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_ADDR_W-1:ADDR_LSB]))
          REG_PERIOD:     period_q032 = pwdata[PERIOD_W-1:0];
          REG_GAIN_POS:   k_pos = pwdata[GAIN_W-1:0];
          REG_GAIN_VEL:   k_vel = pwdata[GAIN_W-1:0];
          REG_GAIN_DIST:  k_dist = pwdata[GAIN_W-1:0];
          REG_INPUT_GAIN: b0_gain = pwdata[IGAIN_W-1:0];
          default: ;
        endcase
      end
    end
    errors <= fail_count;
    pending <= expected_estimates.size();
    checked <= checked_count;
  end

endmodule

[dv/tb.sv]
// Top of the second_order_leso_update bench: clock, reset, beat and register stimulus,
// random stalls, and the verdict. Checking lives in leso_update_checker.
// Depends on soleso_pkg and the RTL top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import soleso_pkg::*;

  localparam int SW = 32;
  localparam int FB = 16;
  localparam int DRAIN_CYCLES = 80;      // a bit over one update
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [SW-1:0] WORD_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] WORD_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic signed [SW-1:0] measured_output = '0;
  logic signed [SW-1:0] control_input = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] position_estimate;
  logic signed [SW-1:0] velocity_estimate;
  logic signed [SW-1:0] disturbance_estimate;
  logic is_initialized;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  int errors;
  int pending;
  int checked;
  int cycles = 0;
  int beats_sent = 0;
  int settings_loaded = 0;
  int plant_y = 0;
  bit steady = 1'b0;

  second_order_leso_update #(.STATE_WIDTH(SW), .FRACTION_BITS(FB)) dut (.*);

  leso_update_checker #(.STATE_WIDTH(SW), .FRACTION_BITS(FB)) observer_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic int pick_wait();
    if (steady) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic signed [SW-1:0] any_word();
    case ($urandom_range(0, 5))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return SW'(int'($urandom_range(0, 511)) - 256);
      default: return SW'($urandom());
    endcase
  endfunction

  task automatic push_beat(command_t op, logic signed [SW-1:0] y, logic signed [SW-1:0] u);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= op;
    measured_output <= y;
    control_input <= u;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // drop valid and wait until every result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, {ADDR_LSB{1'b0}}};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(logic [PERIOD_W-1:0] period, logic [GAIN_W-1:0] kp,
                               logic [GAIN_W-1:0] kv, logic [GAIN_W-1:0] kd,
                               logic signed [IGAIN_W-1:0] b0);
    write_reg(REG_PERIOD, APB_DATA_W'(period));
    write_reg(REG_GAIN_POS, APB_DATA_W'(kp));
    write_reg(REG_GAIN_VEL, APB_DATA_W'(kv));
    write_reg(REG_GAIN_DIST, APB_DATA_W'(kd));
    write_reg(REG_INPUT_GAIN, {{(APB_DATA_W-IGAIN_W){1'b0}}, b0});
    settings_loaded++;
  endtask

  // gains from a bandwidth w0: 3*w0, 3*w0^2, w0^3, with T*w0 well below one
  task automatic load_tracking_settings();
    longint w0;
    longint b0;
    w0 = $urandom_range(5, 120);
    b0 = $urandom_range(16384, 262144);
    if ($urandom_range(0, 1) == 1) b0 = -b0;
    load_settings(PERIOD_W'($urandom_range(1000000, 8000000)), GAIN_W'(3 * w0) << FB,
                  GAIN_W'(3 * w0 * w0) << FB, GAIN_W'(w0 * w0 * w0) << FB, IGAIN_W'(b0));
  endtask

  // measurement follows a slow random walk; a few inits and wild samples mixed in
  task automatic run_tracking(int count);
    int pick;
    int u;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      plant_y = plant_y + int'($urandom_range(0, 8191)) - 4096;
      u = int'($urandom_range(0, 131071)) - 65536;
      if (pick == 0)
        push_beat(CMD_INIT, SW'(plant_y), SW'(u));
      else if (pick == 1)
        push_beat(CMD_UPDATE, any_word(), any_word());
      else
        push_beat(CMD_UPDATE, SW'(plant_y), SW'(u));
    end
  endtask

  task automatic run_scatter(int count);
    for (int i = 0; i < count; i++)
      push_beat(($urandom_range(0, 7) == 0) ? CMD_INIT : CMD_UPDATE, any_word(), any_word());
  endtask

  // receiver: random stall ahead of each result beat
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      hold = pick_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: updates before any init, then first and repeated init
    push_beat(CMD_UPDATE, '0, '0);
    push_beat(CMD_UPDATE, WORD_MAX, WORD_MAX);
    push_beat(CMD_UPDATE, WORD_MIN, WORD_MIN);
    push_beat(CMD_UPDATE, -1, 1);
    push_beat(CMD_INIT, WORD_MAX, '0);
    push_beat(CMD_INIT, WORD_MIN, WORD_MAX);
    push_beat(CMD_UPDATE, WORD_MAX, '0);
    settle();

    // everything at its rail: drives the states into saturation both ways
    load_settings('1, GAIN_MAX, GAIN_MAX, GAIN_MAX, WORD_MIN);
    push_beat(CMD_UPDATE, WORD_MIN, WORD_MAX);
    push_beat(CMD_UPDATE, WORD_MIN, WORD_MAX);
    push_beat(CMD_UPDATE, WORD_MAX, WORD_MIN);
    push_beat(CMD_UPDATE, WORD_MAX, WORD_MIN);
    push_beat(CMD_UPDATE, '0, '0);
    push_beat(CMD_UPDATE, WORD_MAX, WORD_MAX);
    push_beat(CMD_INIT, '0, '0);
    push_beat(CMD_UPDATE, WORD_MIN, WORD_MIN);
    settle();

    load_tracking_settings();
    plant_y = int'(position_estimate);
    run_tracking(110);
    settle();

    load_settings('1, GAIN_MAX, GAIN_MAX, GAIN_MAX, WORD_MIN);
    run_scatter(80);
    settle();

    // zero period freezes the states regardless of gains
    load_settings('0, GAIN_MAX, GAIN_MAX, GAIN_MAX, WORD_MAX);
    run_scatter(30);
    settle();

    // no error feedback: double integration of the control plus the frozen disturbance
    load_settings('1, '0, '0, '0, WORD_MAX);
    run_scatter(30);
    settle();

    steady = 1'b1;
    load_tracking_settings();
    run_tracking(120);
    settle();
    steady = 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      load_settings(PERIOD_W'($urandom()),
                    GAIN_W'({16'($urandom()), 32'($urandom())}) >> $urandom_range(0, 47),
                    GAIN_W'({16'($urandom()), 32'($urandom())}) >> $urandom_range(0, 47),
                    GAIN_W'({16'($urandom()), 32'($urandom())}) >> $urandom_range(0, 47),
                    IGAIN_W'($urandom()));
      run_scatter(40);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d beats under %0d register settings, %0d results checked",
             beats_sent, settings_loaded, checked);
    $display("first and repeated init, updates before init, rail saturation, zero period");
    if (errors == 0 && pending == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

[second_order_leso_update.f]
+incdir+hw/rtl
hw/rtl/soleso_pkg.sv
hw/rtl/soleso_regs.sv
hw/rtl/soleso_ctrl.sv
hw/rtl/soleso_dp.sv
hw/rtl/second_order_leso_update.sv
hw/rtl/soleso_checker.sv
dv/leso_update_checker.sv
dv/tb.sv
